/* src/psl_pkg.sv */
// Package for the per-symbol position ledger: types, constants and op codes.
`timescale 1ns / 1ps
package psl_pkg;

  localparam int unsigned SymbolCount = 1024;
  localparam int unsigned SymW = 10;
  localparam int unsigned AddrW = (SymbolCount > 1) ? $clog2(SymbolCount) : 1;
  localparam int unsigned WordW = 64;
  localparam int unsigned EntryW = 6 * WordW;

  typedef enum logic [2:0] {
    OpFill   = 3'd0,
    OpAdd    = 3'd1,
    OpRemove = 3'd2,
    OpClear  = 3'd3,
    OpQuery  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNoSymbol = 2'd1,
    StNegative = 2'd2,
    StZeroFill = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SInit,
    SIdle,
    SRead,
    SMul,
    SWrite,
    SProf,
    SOut
  } state_e;

  typedef struct packed {
    logic [WordW-1:0] net;
    logic [WordW-1:0] notional;
    logic [WordW-1:0] bought;
    logic [WordW-1:0] sold;
    logic [WordW-1:0] bid;
    logic [WordW-1:0] ask;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;   // latch the incoming item
    logic clr_wr;    // write zeros at the sweep address
    logic rd;        // read the entry of the latched item
    logic mul;       // register price times lots
    logic upd;       // compute and write back the entry, register net times mark
    logic prof;      // finish profit and exposure
    logic out_load;  // load the result register
  } ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_done;
    logic no_symbol;
  } stat_t;

endpackage

/* src/psl_ctrl.sv */
// Controller state machine of the position ledger.
`timescale 1ns / 1ps
module psl_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  psl_pkg::stat_t stat_i,
  output psl_pkg::ctrl_t ctrl_o
);

  psl_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psl_pkg::SInit;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      psl_pkg::SInit:  if (stat_i.clr_done) state_d = psl_pkg::SIdle;
      psl_pkg::SIdle:  if (in_valid_i) state_d = psl_pkg::SRead;
      psl_pkg::SRead:  state_d = stat_i.no_symbol ? psl_pkg::SOut : psl_pkg::SMul;
      psl_pkg::SMul:   state_d = psl_pkg::SWrite;
      psl_pkg::SWrite: state_d = psl_pkg::SProf;
      psl_pkg::SProf:  state_d = psl_pkg::SOut;
      psl_pkg::SOut:   if (!out_valid_q || out_ready_i) state_d = psl_pkg::SIdle;
      default:         state_d = psl_pkg::SInit;
    endcase
  end

  always_comb begin
    ctrl_o          = '0;
    in_ready_o      = 1'b0;
    out_valid_d     = out_valid_q && !out_ready_i;
    case (state_q)
      psl_pkg::SInit: ctrl_o.clr_wr = 1'b1;
      psl_pkg::SIdle: begin
        in_ready_o     = 1'b1;
        ctrl_o.capture = in_valid_i;
      end
      psl_pkg::SRead:  ctrl_o.rd = 1'b1;
      psl_pkg::SMul:   ctrl_o.mul = 1'b1;
      psl_pkg::SWrite: ctrl_o.upd = 1'b1;
      psl_pkg::SProf:  ctrl_o.prof = 1'b1;
      psl_pkg::SOut: begin
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.out_load = 1'b1;
          out_valid_d     = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

/* src/psl_datapath.sv */
// Datapath of the position ledger: entry memory, arithmetic and result register.
`timescale 1ns / 1ps
module psl_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  psl_pkg::ctrl_t ctrl_i,
  output psl_pkg::stat_t stat_o,
  input  logic [2:0]     op_i,
  input  logic [9:0]     symbol_i,
  input  logic           side_i,
  input  logic [31:0]    price_i,
  input  logic [31:0]    lots_i,
  input  logic [31:0]    mark_price_i,
  output logic [1:0]     status_o,
  output logic [63:0]    net_position_o,
  output logic [63:0]    net_value_o,
  output logic [63:0]    total_bought_o,
  output logic [63:0]    total_sold_o,
  output logic [63:0]    open_bid_qty_o,
  output logic [63:0]    open_ask_qty_o,
  output logic [63:0]    gross_exposure_o,
  output logic [63:0]    profit_o
);

  localparam int unsigned AW = psl_pkg::AddrW;

  psl_pkg::entry_t mem_q [psl_pkg::SymbolCount];

  logic [AW:0]  clr_cnt_q;
  logic [2:0]   op_q;
  logic [9:0]   sym_q;
  logic         side_q;
  logic [31:0]  price_q, lots_q, mark_q;
  psl_pkg::entry_t rd_q, ent_q;
  logic [63:0]  notional_q, pl_lo_q, pl_hi_q, prof_q, gross_q;
  logic [1:0]   status_q;
  logic         nosym;

  assign nosym = {22'd0, sym_q} >= 32'(psl_pkg::SymbolCount);
  assign stat_o.no_symbol = nosym;
  assign stat_o.clr_done  = clr_cnt_q == (AW+1)'(psl_pkg::SymbolCount - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_cnt_q <= '0;
    else if (ctrl_i.clr_wr && !stat_o.clr_done) clr_cnt_q <= clr_cnt_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      op_q    <= op_i;
      sym_q   <= symbol_i;
      side_q  <= side_i;
      price_q <= price_i;
      lots_q  <= lots_i;
      mark_q  <= mark_price_i;
    end
  end

  psl_pkg::entry_t nxt;
  logic [1:0] st_d;
  logic [63:0] lots64, slot;

  // Single-port entry memory: sweep writes, item writes, one registered read.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr_wr) mem_q[clr_cnt_q[AW-1:0]] <= '0;
    else if (ctrl_i.upd) mem_q[sym_q[AW-1:0]] <= nxt;
    if (ctrl_i.rd) rd_q <= mem_q[sym_q[AW-1:0]];
  end

  assign lots64 = {32'd0, lots_q};

  always_comb begin
    nxt  = rd_q;
    st_d = psl_pkg::StOk;
    slot = (side_q ? rd_q.ask : rd_q.bid) - lots64;
    case (psl_pkg::op_e'(op_q))
      psl_pkg::OpFill: begin
        if (lots_q == 32'd0) st_d = psl_pkg::StZeroFill;
        else if (side_q) begin
          nxt.net      = rd_q.net - lots64;
          nxt.notional = rd_q.notional - notional_q;
          nxt.sold     = rd_q.sold + lots64;
        end else begin
          nxt.net      = rd_q.net + lots64;
          nxt.notional = rd_q.notional + notional_q;
          nxt.bought   = rd_q.bought + lots64;
        end
      end
      psl_pkg::OpAdd: begin
        if (side_q) nxt.ask = rd_q.ask + lots64;
        else nxt.bid = rd_q.bid + lots64;
      end
      psl_pkg::OpRemove: begin
        if (side_q) nxt.ask = slot;
        else nxt.bid = slot;
        if (slot[63]) st_d = psl_pkg::StNegative;
      end
      psl_pkg::OpClear: nxt = '0;
      default: ;
    endcase
  end

  // Profit is net*mark minus notional, mod 2^64, with net*mark built from two 32x32 partial products.
  logic [63:0] g1, g2, a1, a2;
  assign g1 = ent_q.net + ent_q.bid;
  assign g2 = ent_q.net - ent_q.ask;
  assign a1 = g1[63] ? -g1 : g1;
  assign a2 = g2[63] ? -g2 : g2;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) notional_q <= {32'd0, price_q} * {32'd0, lots_q};
    if (ctrl_i.upd) begin
      ent_q    <= nxt;
      status_q <= st_d;
      pl_lo_q  <= {32'd0, nxt.net[31:0]} * {32'd0, mark_q};
      pl_hi_q  <= {32'd0, nxt.net[63:32]} * {32'd0, mark_q};
    end
    if (ctrl_i.prof) begin
      prof_q  <= pl_lo_q + {pl_hi_q[31:0], 32'd0} - ent_q.notional;
      gross_q <= ($signed(a1) > $signed(a2)) ? a1 : a2;
    end
    if (ctrl_i.out_load) begin
      if (nosym) begin
        status_o         <= psl_pkg::StNoSymbol;
        net_position_o   <= '0;
        net_value_o      <= '0;
        total_bought_o   <= '0;
        total_sold_o     <= '0;
        open_bid_qty_o   <= '0;
        open_ask_qty_o   <= '0;
        gross_exposure_o <= '0;
        profit_o         <= '0;
      end else begin
        status_o         <= status_q;
        net_position_o   <= ent_q.net;
        net_value_o      <= ent_q.notional;
        total_bought_o   <= ent_q.bought;
        total_sold_o     <= ent_q.sold;
        open_bid_qty_o   <= ent_q.bid;
        open_ask_qty_o   <= ent_q.ask;
        gross_exposure_o <= gross_q;
        profit_o         <= prof_q;
      end
    end
  end

endmodule

/* src/per_symbol_position_ledger_unit.sv */
// Top level of the per-symbol position ledger.
// Channel | Signals                       | Direction
// in      | in_valid_i / in_ready_o       | item in: op, symbol, side, prices, lots
// out     | out_valid_o / out_ready_i     | item out: status, entry, exposure, profit
// An item steps through read, multiply, write back, profit and load before its
// result is valid; the single-port entry memory and its read-modify-write
// sequence set that order, so a new item is taken only once the last is loaded.
// After reset a clearing pass writes zero to all 1024 entries before the first
// item is accepted.
// A stalled result holds in the output register; the next item is still taken
// and worked through, then waits in its load step, which holds the input off.
`timescale 1ns / 1ps
module per_symbol_position_ledger_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [9:0]  symbol_i,
  input  logic        side_i,
  input  logic [31:0] price_i,
  input  logic [31:0] lots_i,
  input  logic [31:0] mark_price_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [63:0] net_position_o,
  output logic [63:0] net_value_o,
  output logic [63:0] total_bought_o,
  output logic [63:0] total_sold_o,
  output logic [63:0] open_bid_qty_o,
  output logic [63:0] open_ask_qty_o,
  output logic [63:0] gross_exposure_o,
  output logic [63:0] profit_o
);

  psl_pkg::ctrl_t ctrl;
  psl_pkg::stat_t stat;

  psl_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .ctrl_o(ctrl)
  );

  psl_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .op_i, .symbol_i, .side_i, .price_i, .lots_i, .mark_price_i,
    .status_o, .net_position_o, .net_value_o, .total_bought_o, .total_sold_o,
    .open_bid_qty_o, .open_ask_qty_o, .gross_exposure_o, .profit_o
  );

endmodule

/* src/psl_checker.sv */
// Port-level checker for the position ledger, bound to the top level.
`timescale 1ns / 1ps
module psl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [63:0] net_position_o
);

  // An accepted item is not followed by another acceptance next cycle.
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("back to back accept");

  // The input stays closed while the item works through its five steps.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o [*5]) else $error("input reopened early");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(net_position_o)
    && $stable(status_o)) else $error("stalled result changed");

endmodule

bind per_symbol_position_ledger_unit psl_checker u_psl_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .status_o, .net_position_o
);
